// File: rtl/rps_pkg.sv
// ----------------------------------------------------------------------------
// rps_pkg
// Shared constants and types for the roulette parent selector: field widths,
// item mode codes and the command/status bundles between control and datapath.
// ----------------------------------------------------------------------------
package rps_pkg;

    localparam int POP_MAX = 64;
    localparam int IDX_W   = $clog2(POP_MAX);
    localparam int POP_W   = $clog2(POP_MAX + 1);
    localparam int FIT_W   = 16;
    localparam int FRAC_W  = 16;
    localparam int SUM_W   = FIT_W + IDX_W;
    localparam int TGT_W   = SUM_W + FRAC_W;
    localparam int MODE_W  = 2;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SELECT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    localparam logic [POP_W-1:0] POP_RESET = POP_W'(POP_MAX);

    typedef enum logic {
        RD_SUM,
        RD_WALK
    } rd_op_t;

    typedef struct packed {
        logic             load_en;
        logic             clear_marks;
        logic             start;
        logic             rd_en;
        rd_op_t           rd_op;
        logic [IDX_W-1:0] rd_addr;
        logic             mul_en;
        logic             commit;
    } cmd_t;

    typedef struct packed {
        logic found;
        logic out_busy;
    } status_t;

endpackage

// File: rtl/roulette_parent_selector_unit.sv
// ----------------------------------------------------------------------------
// roulette_parent_selector_unit
// Fitness-proportionate parent selection without replacement.
// ----------------------------------------------------------------------------
// Load items (mode 0) write one slot's fitness and clear items (mode 2) drop
// all selected marks; both give no result. A select item (mode 1) gives one
// result: it makes one pass over the P slots in use to sum the unselected
// fitnesses, scales the random fraction by that sum, then walks the slots
// again until the running sum reaches the target, so the walk ends early on
// an early hit. Both passes go through the single read port of the fitness
// memory, and the result waits while the previous one is held by out_stall.
// A zero unselected sum returns slot 0 with fell_back set and marks nothing.
// Fitness of a slot is undefined until it has been loaded.
module roulette_parent_selector_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [rps_pkg::POP_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [rps_pkg::MODE_W-1:0]  mode,
    input  logic [rps_pkg::IDX_W-1:0]   slot,
    input  logic [rps_pkg::FIT_W-1:0]   fitness,
    input  logic [rps_pkg::FRAC_W-1:0]  random_fraction,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [rps_pkg::IDX_W-1:0]   chosen_slot,
    output logic                        fell_back
);

    rps_pkg::cmd_t    cmd;
    rps_pkg::status_t status;

    rps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .status   (status),
        .cmd      (cmd)
    );

    rps_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .slot            (slot),
        .fitness         (fitness),
        .random_fraction (random_fraction),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .chosen_slot     (chosen_slot),
        .fell_back       (fell_back)
    );

endmodule

// File: rtl/rps_ctrl.sv
// ----------------------------------------------------------------------------
// rps_ctrl
// Sequencer: holds the population size register, accepts items and steps a
// select item through the sum pass, the scaling multiply and the wheel walk.
// ----------------------------------------------------------------------------
module rps_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [rps_pkg::POP_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [rps_pkg::MODE_W-1:0]  mode,
    input  rps_pkg::status_t            status,
    output rps_pkg::cmd_t               cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_SUM_DRAIN,
        ST_MUL,
        ST_WALK,
        ST_WALK_DRAIN,
        ST_FINISH
    } state_t;

    state_t                     state_reg;
    logic [rps_pkg::IDX_W-1:0]  idx_reg;
    logic [rps_pkg::POP_W-1:0]  pop_reg;
    logic [rps_pkg::IDX_W-1:0]  p_last;
    logic                       accept;
    logic                       idx_last;

    // size 0 acts as 1, anything above the store depth acts as the depth
    always_comb
    begin
        if (pop_reg == '0)
        begin
            p_last = '0;
        end
        else if (pop_reg >= rps_pkg::POP_RESET)
        begin
            p_last = rps_pkg::IDX_W'(rps_pkg::POP_MAX - 1);
        end
        else
        begin
            p_last = rps_pkg::IDX_W'(pop_reg - rps_pkg::POP_W'(1));
        end
    end

    assign idx_last = (idx_reg == p_last);
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cmd             = '0;
        cmd.rd_op       = rps_pkg::RD_SUM;
        cmd.rd_addr     = idx_reg;
        cmd.load_en     = accept && (mode == rps_pkg::MODE_LOAD);
        cmd.clear_marks = accept && (mode == rps_pkg::MODE_CLEAR);
        cmd.start       = accept && (mode == rps_pkg::MODE_SELECT);
        case (state_reg)
            ST_SUM:
            begin
                cmd.rd_en = 1'b1;
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
            end
            ST_WALK:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_op = rps_pkg::RD_WALK;
            end
            ST_FINISH:
            begin
                cmd.commit = !status.out_busy;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            pop_reg   <= rps_pkg::POP_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                pop_reg <= cfg_data;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    idx_reg <= '0;
                    if (cmd.start)
                    begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM:
                begin
                    if (idx_last)
                    begin
                        state_reg <= ST_SUM_DRAIN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_SUM_DRAIN:
                begin
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    idx_reg   <= '0;
                    state_reg <= ST_WALK;
                end
                ST_WALK:
                begin
                    // reads issued after a hit are still in flight; datapath drops them
                    if (status.found)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else if (idx_last)
                    begin
                        state_reg <= ST_WALK_DRAIN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_WALK_DRAIN:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (!status.out_busy)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/rps_datapath.sv
// ----------------------------------------------------------------------------
// rps_datapath
// Fitness memory, selected marks, sum and running accumulators, the target
// multiplier and the output register.
// ----------------------------------------------------------------------------
module rps_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rps_pkg::cmd_t               cmd,
    output rps_pkg::status_t            status,
    input  logic [rps_pkg::IDX_W-1:0]   slot,
    input  logic [rps_pkg::FIT_W-1:0]   fitness,
    input  logic [rps_pkg::FRAC_W-1:0]  random_fraction,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [rps_pkg::IDX_W-1:0]   chosen_slot,
    output logic                        fell_back
);

    logic [rps_pkg::FIT_W-1:0]  fit_mem [rps_pkg::POP_MAX];
    logic [rps_pkg::POP_MAX-1:0] marks_reg;

    logic [rps_pkg::FIT_W-1:0]  rd_fit_reg;
    logic                       rd_mark_reg;
    logic [rps_pkg::IDX_W-1:0]  rd_idx_reg;
    logic                       rd_valid_reg;
    rps_pkg::rd_op_t            rd_op_reg;

    logic [rps_pkg::FRAC_W-1:0] rnd_reg;
    logic [rps_pkg::SUM_W-1:0]  total_reg;
    logic [rps_pkg::SUM_W-1:0]  running_reg;
    logic [rps_pkg::SUM_W-1:0]  running_next;
    logic [rps_pkg::TGT_W-1:0]  target_reg;
    logic                       found_reg;
    logic [rps_pkg::IDX_W-1:0]  found_idx_reg;

    logic                       out_valid_reg;
    logic [rps_pkg::IDX_W-1:0]  chosen_reg;
    logic                       fell_back_reg;

    logic                       sum_step;
    logic                       walk_step;
    logic                       hit;

    assign sum_step  = rd_valid_reg && (rd_op_reg == rps_pkg::RD_SUM) && !rd_mark_reg;
    assign walk_step = rd_valid_reg && (rd_op_reg == rps_pkg::RD_WALK) && !rd_mark_reg
                       && !found_reg;

    assign running_next = running_reg + rps_pkg::SUM_W'(rd_fit_reg);
    // target <= running * 2^16 replaces target/65536 <= running
    assign hit = walk_step && (rd_fit_reg != '0)
                 && (target_reg <= {running_next, {rps_pkg::FRAC_W{1'b0}}});

    assign status.found    = found_reg;
    assign status.out_busy = out_valid_reg && out_stall;

    assign out_valid   = out_valid_reg;
    assign chosen_slot = chosen_reg;
    assign fell_back   = fell_back_reg;

    // memory port and payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_en)
        begin
            fit_mem[slot] <= fitness;
        end
        if (cmd.rd_en)
        begin
            rd_fit_reg  <= fit_mem[cmd.rd_addr];
            rd_mark_reg <= marks_reg[cmd.rd_addr];
            rd_idx_reg  <= cmd.rd_addr;
            rd_op_reg   <= cmd.rd_op;
        end
        if (cmd.start)
        begin
            rnd_reg <= random_fraction;
        end
        if (cmd.mul_en)
        begin
            target_reg <= rps_pkg::TGT_W'(rnd_reg) * rps_pkg::TGT_W'(total_reg);
        end
        if (hit)
        begin
            found_idx_reg <= rd_idx_reg;
        end
        if (cmd.commit)
        begin
            chosen_reg    <= found_reg ? found_idx_reg : '0;
            fell_back_reg <= !found_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            total_reg     <= '0;
            running_reg   <= '0;
            found_reg     <= 1'b0;
            marks_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_en;
            if (cmd.start)
            begin
                total_reg   <= '0;
                running_reg <= '0;
                found_reg   <= 1'b0;
            end
            else
            begin
                if (sum_step)
                begin
                    total_reg <= total_reg + rps_pkg::SUM_W'(rd_fit_reg);
                end
                if (walk_step)
                begin
                    running_reg <= running_next;
                end
                if (hit)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.clear_marks)
            begin
                marks_reg <= '0;
            end
            else if (cmd.commit && found_reg)
            begin
                marks_reg[found_idx_reg] <= 1'b1;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_fallback_is_slot0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && fell_back_reg |-> chosen_reg == '0)
        else $error("fallback result does not report slot 0");

    a_one_mark_per_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cmd.clear_marks) |->
            $countones(marks_reg) <= $countones($past(marks_reg)) + 1)
        else $error("more than one mark set in a cycle");

    a_running_within_total: assert property (@(posedge clk) disable iff (!rst_n)
        walk_step |-> running_reg <= total_reg)
        else $error("running sum passed the unselected total");

    a_commit_needs_free_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && out_stall))
        else $error("result committed over a stalled output");
`endif

endmodule
